/* rtl/core/sign_split_dot_product_assert.svh */
// ----------------------------------------------------------------------------
// sign split dot product assertion macros
// clocked assertion shorthands used by ssdp_back
// ----------------------------------------------------------------------------
`ifndef SIGN_SPLIT_DOT_PRODUCT_ASSERT_SVH
`define SIGN_SPLIT_DOT_PRODUCT_ASSERT_SVH

// property must hold at every edge outside reset
`define SSDP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define SSDP_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/ssdp_pkg.sv */
// ----------------------------------------------------------------------------
// ssdp_pkg
// shared types, constants and helpers of the sign split dot product
// ----------------------------------------------------------------------------
package ssdp_pkg;

   localparam int SIGN_BIT = 63;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

   // operand class codes
   localparam logic [1:0] KIND_NUM  = 2'd0;
   localparam logic [1:0] KIND_ZERO = 2'd1;
   localparam logic [1:0] KIND_INF  = 2'd2;
   localparam logic [1:0] KIND_NAN  = 2'd3;

   // multiplier pipeline depth
   localparam int MUL_LAT = 5;

   typedef struct packed {
      logic odd;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [63:0] prod;
      logic        odd;
      logic        neg;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic [63:0] pos_sum;
      logic [63:0] neg_sum;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   function automatic logic is_nan(input logic [63:0] b);
      return (b[62:52] == EXP_ALL_ONES) && (b[51:0] != '0);
   endfunction

   function automatic logic is_inf(input logic [63:0] b);
      return (b[62:52] == EXP_ALL_ONES) && (b[51:0] == '0);
   endfunction

   function automatic logic is_zero(input logic [63:0] b);
      return b[62:0] == '0;
   endfunction

endpackage

/* rtl/core/ssdp_fifo.sv */
// ----------------------------------------------------------------------------
// ssdp_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module ssdp_fifo
   import ssdp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output qstat_type                  stat,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == LVL_W'(DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = mem_ff[rd_ptr_ff];
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/ssdp_fmul.sv */
// ----------------------------------------------------------------------------
// ssdp_fmul
// five stage binary64 multiplier, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module ssdp_fmul
   import ssdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  tag_type     in_tag,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        out_valid,
   output tag_type     out_tag,
   output logic [63:0] prod,
   output logic [2:0]  pending
);

   function automatic logic [6:0] lead_zeros(input logic [105:0] p);
      logic [6:0] cnt;
      cnt = 7'd106;
      for (int i = 0; i < 106; i++) begin
         if (p[i]) cnt = 7'(105 - i);
      end
      return cnt;
   endfunction

   logic [MUL_LAT-1:0] valid_ff;
   tag_type            tag_ff [MUL_LAT];

   // stage 1: decode and partial products
   logic [10:0] ea_f, eb_f;
   logic [52:0] ma, mb;
   logic [11:0] esum_in;
   logic [1:0]  kind_in;
   logic [53:0] pp_hh_in;
   logic [52:0] pp_hl_in, pp_lh_in;
   logic [51:0] pp_ll_in;

   logic [11:0] s1_esum_ff;
   logic [1:0]  s1_kind_ff;
   logic        s1_sign_ff;
   logic [53:0] s1_hh_ff;
   logic [52:0] s1_hl_ff, s1_lh_ff;
   logic [51:0] s1_ll_ff;

   assign ea_f    = op_a[62:52];
   assign eb_f    = op_b[62:52];
   assign ma      = {ea_f != '0, op_a[51:0]};
   assign mb      = {eb_f != '0, op_b[51:0]};
   assign esum_in = {1'b0, (ea_f == '0) ? 11'd1 : ea_f} + {1'b0, (eb_f == '0) ? 11'd1 : eb_f};
   assign pp_hh_in = ma[52:26] * mb[52:26];
   assign pp_hl_in = ma[52:26] * mb[25:0];
   assign pp_lh_in = ma[25:0] * mb[52:26];
   assign pp_ll_in = ma[25:0] * mb[25:0];

   always_comb begin
      priority if (is_nan(op_a) || is_nan(op_b) || (is_inf(op_a) && is_zero(op_b)) ||
                   (is_zero(op_a) && is_inf(op_b))) begin
         kind_in = KIND_NAN;
      end else if (is_inf(op_a) || is_inf(op_b)) begin
         kind_in = KIND_INF;
      end else if (is_zero(op_a) || is_zero(op_b)) begin
         kind_in = KIND_ZERO;
      end else begin
         kind_in = KIND_NUM;
      end
   end

   // stage 2: full product
   logic [105:0]       s2_p_ff;
   logic signed [12:0] s2_e0_ff;
   logic [1:0]         s2_kind_ff;
   logic               s2_sign_ff;

   // stage 3: leading zero count
   logic [105:0]       s3_p_ff;
   logic signed [12:0] s3_e0_ff;
   logic [6:0]         s3_lz_ff;
   logic [1:0]         s3_kind_ff;
   logic               s3_sign_ff;

   // stage 4: normalize or denormalize
   logic signed [12:0] e_s4, sh_s;
   logic [12:0]        rs;
   logic [105:0]       n_in;
   logic               st_in;
   logic [12:0]        eres_in;

   logic [105:0] s4_n_ff;
   logic         s4_st_ff;
   logic [12:0]  s4_eres_ff;
   logic [1:0]   s4_kind_ff;
   logic         s4_sign_ff;

   always_comb begin
      e_s4 = s3_e0_ff - $signed({6'b0, s3_lz_ff});
      if (e_s4 >= 13'sd1) begin
         sh_s    = $signed({6'b0, s3_lz_ff});
         eres_in = 13'(e_s4);
      end else begin
         sh_s    = $signed({6'b0, s3_lz_ff}) + e_s4 - 13'sd1;
         eres_in = 13'd1;
      end
      rs = '0;
      if (sh_s >= 13'sd0) begin
         n_in  = s3_p_ff << sh_s[6:0];
         st_in = 1'b0;
      end else begin
         rs = 13'(-sh_s);
         if (rs >= 13'd107) begin
            n_in  = '0;
            st_in = 1'b1;
         end else begin
            n_in  = s3_p_ff >> rs[6:0];
            st_in = (s3_p_ff & ~({106{1'b1}} << rs[6:0])) != '0;
         end
      end
   end

   // stage 5: round and pack
   logic [52:0]  mant5;
   logic         up5;
   logic [53:0]  m2_5;
   logic [52:0]  mant_f;
   logic [12:0]  e_f;
   logic [63:0]  prod_in;
   logic [63:0]  prod_ff;

   always_comb begin
      mant5 = s4_n_ff[105:53];
      up5   = s4_n_ff[52] && ((|s4_n_ff[51:0]) || s4_st_ff || mant5[0]);
      m2_5  = {1'b0, mant5} + 54'(up5);
      if (m2_5[53]) begin
         mant_f = m2_5[53:1];
         e_f    = s4_eres_ff + 13'd1;
      end else begin
         mant_f = m2_5[52:0];
         e_f    = s4_eres_ff;
      end
      unique case (s4_kind_ff)
         KIND_NAN:  prod_in = CANON_NAN;
         KIND_INF:  prod_in = {s4_sign_ff, EXP_ALL_ONES, 52'b0};
         KIND_ZERO: prod_in = {s4_sign_ff, 63'b0};
         default: begin
            if (e_f >= 13'd2047) begin
               prod_in = {s4_sign_ff, EXP_ALL_ONES, 52'b0};
            end else begin
               prod_in = {s4_sign_ff, mant_f[52] ? e_f[10:0] : 11'd0, mant_f[51:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[MUL_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int i = 1; i < MUL_LAT; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
      s1_esum_ff <= esum_in;
      s1_kind_ff <= kind_in;
      s1_sign_ff <= op_a[SIGN_BIT] ^ op_b[SIGN_BIT];
      s1_hh_ff   <= pp_hh_in;
      s1_hl_ff   <= pp_hl_in;
      s1_lh_ff   <= pp_lh_in;
      s1_ll_ff   <= pp_ll_in;

      s2_p_ff    <= ({52'b0, s1_hh_ff} << 52) + ({53'b0, s1_hl_ff} << 26) +
                    ({53'b0, s1_lh_ff} << 26) + {54'b0, s1_ll_ff};
      s2_e0_ff   <= $signed({1'b0, s1_esum_ff}) - 13'sd1022;
      s2_kind_ff <= s1_kind_ff;
      s2_sign_ff <= s1_sign_ff;

      s3_p_ff    <= s2_p_ff;
      s3_e0_ff   <= s2_e0_ff;
      s3_lz_ff   <= lead_zeros(s2_p_ff);
      s3_kind_ff <= s2_kind_ff;
      s3_sign_ff <= s2_sign_ff;

      s4_n_ff    <= n_in;
      s4_st_ff   <= st_in;
      s4_eres_ff <= eres_in;
      s4_kind_ff <= s3_kind_ff;
      s4_sign_ff <= s3_sign_ff;

      prod_ff    <= prod_in;
   end

   assign out_valid = valid_ff[MUL_LAT-1];
   assign out_tag   = tag_ff[MUL_LAT-1];
   assign prod      = prod_ff;
   assign pending   = 3'($countones(valid_ff));

endmodule

/* rtl/core/ssdp_front.sv */
// ----------------------------------------------------------------------------
// ssdp_front
// takes items, tracks vector position, multiplies and classifies by sign
// ----------------------------------------------------------------------------
module ssdp_front
   import ssdp_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [63:0]                op_a,
   input  logic [63:0]                op_b,
   input  logic                       is_last,
   input  logic [$clog2(DEPTH+1)-1:0] q_level,
   output logic                       q_push,
   output cmd_type                    q_cmd
);

   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam int SUM_W = ((LVL_W > 3) ? LVL_W : 3) + 1;

   logic        odd_ff, odd_in;
   logic        accept;
   logic [2:0]  pending;
   tag_type     tag_in, tag_out;
   logic [63:0] prod;

   // credit check: every item in the multiplier has a queue slot kept for it
   assign full   = (SUM_W'(q_level) + SUM_W'(pending)) >= SUM_W'(DEPTH);
   assign accept = push && !full;

   assign tag_in.odd  = odd_ff;
   assign tag_in.last = is_last;
   assign odd_in      = accept ? (is_last ? 1'b0 : !odd_ff) : odd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff <= 1'b0;
      end else begin
         odd_ff <= odd_in;
      end
   end

   ssdp_fmul u_fmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_tag    (tag_in),
      .op_a      (op_a),
      .op_b      (op_b),
      .out_valid (q_push),
      .out_tag   (tag_out),
      .prod      (prod),
      .pending   (pending)
   );

   assign q_cmd.prod = prod;
   assign q_cmd.odd  = tag_out.odd;
   assign q_cmd.neg  = prod[SIGN_BIT];
   assign q_cmd.last = tag_out.last;

endmodule

/* rtl/core/ssdp_fadd.sv */
// ----------------------------------------------------------------------------
// ssdp_fadd
// three stage binary64 adder for operands of equal sign or zero
// ----------------------------------------------------------------------------
module ssdp_fadd
   import ssdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic        in_tag,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic        out_valid,
   output logic        out_tag,
   output logic [63:0] sum
);

   // stage 1: specials, swap, align
   logic        spec_in;
   logic [63:0] spec_val_in;
   logic        swap;
   logic [63:0] big, sml;
   logic [10:0] eb, es, d;
   logic [52:0] mb_in, ms;
   logic [55:0] ext, shd, al_in;
   logic        lost;

   always_comb begin
      spec_in = 1'b1;
      priority if (is_nan(x) || is_nan(y)) begin
         spec_val_in = CANON_NAN;
      end else if (is_inf(x)) begin
         spec_val_in = x;
      end else if (is_inf(y)) begin
         spec_val_in = y;
      end else if (is_zero(x) && is_zero(y)) begin
         spec_val_in = {x[SIGN_BIT] & y[SIGN_BIT], 63'b0};
      end else if (is_zero(x)) begin
         spec_val_in = y;
      end else if (is_zero(y)) begin
         spec_val_in = x;
      end else begin
         spec_val_in = '0;
         spec_in     = 1'b0;
      end
   end

   always_comb begin
      swap  = y[62:0] > x[62:0];
      big   = swap ? y : x;
      sml   = swap ? x : y;
      eb    = (big[62:52] == '0) ? 11'd1 : big[62:52];
      es    = (sml[62:52] == '0) ? 11'd1 : sml[62:52];
      d     = eb - es;
      mb_in = {big[62:52] != '0, big[51:0]};
      ms    = {sml[62:52] != '0, sml[51:0]};
      ext   = {ms, 3'b0};
      shd   = '0;
      lost  = 1'b0;
      if (d >= 11'd56) begin
         al_in = 56'd1;
      end else begin
         shd   = ext >> d[5:0];
         lost  = (ext & ~({56{1'b1}} << d[5:0])) != '0;
         al_in = {shd[55:1], shd[0] | lost};
      end
   end

   logic [2:0]  valid_ff;
   logic [2:0]  tag_ff;
   logic        s1_spec_ff, s2_spec_ff;
   logic [63:0] s1_sval_ff, s2_sval_ff;
   logic        s1_sign_ff, s2_sign_ff;
   logic [10:0] s1_e_ff;
   logic [52:0] s1_mb_ff;
   logic [55:0] s1_al_ff;
   logic [55:0] s2_t_ff;
   logic [11:0] s2_e_ff;

   // stage 2: add with one bit carry normalize
   logic [56:0] s_sum;
   logic [55:0] t_in;
   logic [11:0] e2_in;

   always_comb begin
      s_sum = {1'b0, s1_mb_ff, 3'b0} + {1'b0, s1_al_ff};
      if (s_sum[56]) begin
         t_in  = {s_sum[56:2], s_sum[1] | s_sum[0]};
         e2_in = {1'b0, s1_e_ff} + 12'd1;
      end else begin
         t_in  = s_sum[55:0];
         e2_in = {1'b0, s1_e_ff};
      end
   end

   // stage 3: round and pack
   logic [52:0] mant;
   logic        up;
   logic [53:0] m2;
   logic [52:0] mant_f;
   logic [11:0] e_f;
   logic [63:0] sum_in;
   logic [63:0] sum_ff;

   always_comb begin
      mant = s2_t_ff[55:3];
      up   = s2_t_ff[2] && ((|s2_t_ff[1:0]) || mant[0]);
      m2   = {1'b0, mant} + 54'(up);
      if (m2[53]) begin
         mant_f = m2[53:1];
         e_f    = s2_e_ff + 12'd1;
      end else begin
         mant_f = m2[52:0];
         e_f    = s2_e_ff;
      end
      if (s2_spec_ff) begin
         sum_in = s2_sval_ff;
      end else if (e_f >= 12'd2047) begin
         sum_in = {s2_sign_ff, EXP_ALL_ONES, 52'b0};
      end else begin
         sum_in = {s2_sign_ff, mant_f[52] ? e_f[10:0] : 11'd0, mant_f[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff     <= {tag_ff[1:0], in_tag};
      s1_spec_ff <= spec_in;
      s1_sval_ff <= spec_val_in;
      s1_sign_ff <= big[SIGN_BIT];
      s1_e_ff    <= eb;
      s1_mb_ff   <= mb_in;
      s1_al_ff   <= al_in;
      s2_spec_ff <= s1_spec_ff;
      s2_sval_ff <= s1_sval_ff;
      s2_sign_ff <= s1_sign_ff;
      s2_t_ff    <= t_in;
      s2_e_ff    <= e2_in;
      sum_ff     <= sum_in;
   end

   assign out_valid = valid_ff[2];
   assign out_tag   = tag_ff[2];
   assign sum       = sum_ff;

endmodule

/* rtl/core/ssdp_back.sv */
// ----------------------------------------------------------------------------
// ssdp_back
// accumulates products into four sign and parity split sums, forms results
// ----------------------------------------------------------------------------
`include "sign_split_dot_product_assert.svh"

module ssdp_back
   import ssdp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  qstat_type cmd_stat,
   output logic      cmd_pop,
   input  qstat_type out_stat,
   output logic      out_push,
   output rsp_type   out_data
);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_ACC   = 3'd1;
   localparam logic [2:0] B_FIN   = 3'd2;
   localparam logic [2:0] B_FIN2  = 3'd3;
   localparam logic [2:0] B_FWAIT = 3'd4;

   localparam logic TAG_POS = 1'b0;
   localparam logic TAG_NEG = 1'b1;

   // accumulator index is {odd, neg}
   localparam logic [1:0] IDX_EVEN_POS = 2'd0;
   localparam logic [1:0] IDX_EVEN_NEG = 2'd1;
   localparam logic [1:0] IDX_ODD_POS  = 2'd2;
   localparam logic [1:0] IDX_ODD_NEG  = 2'd3;

   logic [2:0]  state_ff, state_in;
   logic [63:0] acc_ff [4];
   logic [1:0]  sel_ff;
   logic        last_ff;
   logic [63:0] pos_hold_ff;

   logic        add_valid, add_tag;
   logic [63:0] add_x, add_y;
   logic        add_out_valid, add_out_tag;
   logic [63:0] add_sum;

   always_comb begin
      state_in  = state_ff;
      add_valid = 1'b0;
      add_tag   = TAG_POS;
      add_x     = acc_ff[{cmd.odd, cmd.neg}];
      add_y     = cmd.prod;
      cmd_pop   = 1'b0;
      out_push  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_stat.empty) begin
               cmd_pop   = 1'b1;
               add_valid = 1'b1;
               state_in  = B_ACC;
            end
         end
         B_ACC: begin
            if (add_out_valid) begin
               state_in = last_ff ? B_FIN : B_IDLE;
            end
         end
         B_FIN: begin
            if (!out_stat.full) begin
               add_valid = 1'b1;
               add_tag   = TAG_POS;
               add_x     = acc_ff[IDX_EVEN_POS];
               add_y     = acc_ff[IDX_ODD_POS];
               state_in  = B_FIN2;
            end
         end
         B_FIN2: begin
            add_valid = 1'b1;
            add_tag   = TAG_NEG;
            add_x     = acc_ff[IDX_EVEN_NEG];
            add_y     = acc_ff[IDX_ODD_NEG];
            state_in  = B_FWAIT;
         end
         B_FWAIT: begin
            if (add_out_valid && (add_out_tag == TAG_NEG)) begin
               out_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign out_data.pos_sum = pos_hold_ff;
   assign out_data.neg_sum = add_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == B_ACC && add_out_valid) begin
            acc_ff[sel_ff] <= add_sum;
         end
         if (out_push) begin
            for (int i = 0; i < 4; i++) begin
               acc_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         sel_ff  <= {cmd.odd, cmd.neg};
         last_ff <= cmd.last;
      end
      if (state_ff == B_FWAIT && add_out_valid && add_out_tag == TAG_POS) begin
         pos_hold_ff <= add_sum;
      end
   end

   ssdp_fadd u_fadd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (add_valid),
      .in_tag    (add_tag),
      .x         (add_x),
      .y         (add_y),
      .out_valid (add_out_valid),
      .out_tag   (add_out_tag),
      .sum       (add_sum)
   );

   `SSDP_ASSERT(a_result_expected, clock, reset, add_out_valid |-> (state_ff == B_ACC || state_ff == B_FWAIT), "adder result with no add pending")
   `SSDP_NEVER(a_push_room, clock, reset, out_push && out_stat.full, "result pushed into a full queue")
   `SSDP_ASSERT(a_pop_idle, clock, reset, cmd_pop |=> (state_ff == B_ACC), "command taken without add")

endmodule

/* rtl/core/sign_split_dot_product.sv */
// ----------------------------------------------------------------------------
// sign_split_dot_product
// binary64 dot product with positive and negative products summed apart
// a last item reaches its result through multiply, queue write, accumulate
//   and the final pair of sums; each item queued ahead delays it
// the back takes a new item only when the accumulate loop through the
//   3 stage adder is done with the one before; a last item also holds the
//   back for its final pair of sums; bursts up to the command queue depth
//   enter back to back
// reset: synchronous, clears queues, pipeline valids, position and sums
// ----------------------------------------------------------------------------
module sign_split_dot_product
   import ssdp_pkg::*;
#(
   parameter int CMD_DEPTH = 8,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_op_a,
   input  logic [63:0] req_op_b,
   input  logic        req_is_last,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_pos_sum,
   output logic [63:0] rsp_neg_sum
);

   // command queue between the multiplier front and the accumulating back
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;
   logic                           cmd_push, cmd_pop;
   cmd_type                        cmd_wr, cmd_rd;
   qstat_type                      cmd_stat;

   // result queue so the back keeps going while a result waits
   logic      out_push;
   rsp_type   out_wr, out_rd;
   qstat_type out_stat;
   logic [$clog2(RSP_DEPTH+1)-1:0] out_level;

   // front: position tracking, multiply, sign classify
   ssdp_front #(
      .DEPTH (CMD_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .op_a    (req_op_a),
      .op_b    (req_op_b),
      .is_last (req_is_last),
      .q_level (cmd_level),
      .q_push  (cmd_push),
      .q_cmd   (cmd_wr)
   );

   ssdp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .stat  (cmd_stat),
      .level (cmd_level)
   );

   // back: four accumulators, final sums on the last item
   ssdp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_rd),
      .cmd_stat (cmd_stat),
      .cmd_pop  (cmd_pop),
      .out_stat (out_stat),
      .out_push (out_push),
      .out_data (out_wr)
   );

   ssdp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wr),
      .pop   (pop),
      .rdata (out_rd),
      .stat  (out_stat),
      .level (out_level)
   );

   // result side looks like the read end of a queue
   assign empty       = out_stat.empty || (out_level == '0);
   assign rsp_pos_sum = out_rd.pos_sum;
   assign rsp_neg_sum = out_rd.neg_sum;

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// sign split dot product testbench
// drives binary64 operand pairs through the push/full queue, predicts the
// positive and negative sums with host double arithmetic and checks every
// popped result in order, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;
   import ssdp_pkg::*;

   localparam logic [63:0] QNAN      = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF   = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_NORM  = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_SUB   = 64'h0000_0000_0000_0001;
   localparam logic [63:0] MAX_SUB   = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] ONE       = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] MINUS_TWO = 64'hC000_0000_0000_0000;
   localparam logic [63:0] SNAN      = 64'hFFF0_0000_0000_0001;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [63:0] pos_sum;
      logic [63:0] neg_sum;
   } sums_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [63:0] req_op_a;
   logic [63:0] req_op_b;
   logic        req_is_last;
   logic        empty;
   logic        pop;
   logic [63:0] rsp_pos_sum;
   logic [63:0] rsp_neg_sum;

   // predicted sums waiting for the block, oldest first
   sums_type pending_sums[$];

   // own copy of the accumulator state
   real even_pos, even_neg, odd_pos, odd_neg;
   bit  at_odd;

   bit failed;
   bit tx_idle_en;
   bit rx_idle_en;
   int rsp_hold_cycles;
   int rx_burst;
   int quiet_cycles;

   sign_split_dot_product dut (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_op_a   (req_op_a),
      .req_op_b   (req_op_b),
      .req_is_last(req_is_last),
      .empty      (empty),
      .pop        (pop),
      .rsp_pos_sum(rsp_pos_sum),
      .rsp_neg_sum(rsp_neg_sum)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic bit nan_bits(input logic [63:0] b);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
   endfunction

   // any nan leaves as the one quiet nan pattern
   function automatic logic [63:0] canon(input real v);
      logic [63:0] b;
      b = $realtobits(v);
      return nan_bits(b) ? QNAN : b;
   endfunction

   task automatic clear_sums();
      even_pos = $bitstoreal(64'd0);
      even_neg = $bitstoreal(64'd0);
      odd_pos = $bitstoreal(64'd0);
      odd_neg = $bitstoreal(64'd0);
      at_odd = 1'b0;
   endtask

   // fold one accepted pair into the accumulators, queue the sums on last
   task automatic accumulate_pair(input logic [63:0] a, input logic [63:0] b,
                                  input logic last);
      real   prod;
      logic [63:0] pbits;
      sums_type s;
      prod = $bitstoreal(a) * $bitstoreal(b);
      pbits = $realtobits(prod);
      if (nan_bits(pbits)) begin
         pbits = QNAN;
         prod = $bitstoreal(QNAN);
      end
      // sign bit picks the accumulator, so negative zero goes negative
      if (at_odd) begin
         if (pbits[63]) odd_neg = odd_neg + prod;
         else odd_pos = odd_pos + prod;
      end else begin
         if (pbits[63]) even_neg = even_neg + prod;
         else even_pos = even_pos + prod;
      end
      at_odd = !at_odd;
      if (last) begin
         s.pos_sum = canon(even_pos + odd_pos);
         s.neg_sum = canon(even_neg + odd_neg);
         pending_sums.push_back(s);
         clear_sums();
      end
   endtask

   // offer one item from the next falling edge until it is taken
   task automatic send_item(input logic [63:0] a, input logic [63:0] b,
                            input logic last);
      int gap;
      @(negedge clock);
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_op_a <= a;
      req_op_b <= b;
      req_is_last <= last;
      do @(posedge clock); while (full);
      accumulate_pair(a, b, last);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      push <= 1'b0;
   endtask

   // mostly tame magnitudes so sums stay finite, with raw patterns mixed in
   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: ;                                    // raw bits, any class
         1: v[62:52] = 11'd0;                    // subnormal or zero
         2: v[62:0] = 63'd0;                     // signed zero
         default: v[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
      endcase
      return v;
   endfunction

   task automatic send_vector(input int len);
      for (int i = 0; i < len; i++)
         send_item(rand_operand(), rand_operand(), i == len - 1);
   endtask

   // receiver: long hold when asked, else random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         pop <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if (rx_burst > 0) begin
         pop <= 1'b0;
         rx_burst <= rx_burst - 1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
         pop <= 1'b0;
         rx_burst <= $urandom_range(0, 12);
      end else begin
         pop <= 1'b1;
      end
   end

   // compare each popped result with the oldest prediction
   always @(posedge clock) begin
      sums_type want;
      if (!reset && pop && !empty) begin
         if (pending_sums.size() == 0) begin
            $error("result popped with no sums predicted");
            failed = 1'b1;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_pos_sum !== want.pos_sum) begin
               $error("pos_sum expected %h actual %h", want.pos_sum, rsp_pos_sum);
               failed = 1'b1;
            end
            if (rsp_neg_sum !== want.neg_sum) begin
               $error("neg_sum expected %h actual %h", want.neg_sum, rsp_neg_sum);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles where neither side moves an item
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[sign_split_dot_product] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // extremes and each class of product
   task automatic test_directed();
      send_item(ONE, ONE, 1'b1);                  // single item vector
      send_item(ONE, MINUS_TWO, 1'b0);
      send_item(NEG_ZERO, ONE, 1'b0);             // negative zero product
      send_item(64'd0, MINUS_TWO, 1'b0);
      send_item(ONE, ONE, 1'b1);
      send_item(POS_INF, ONE, 1'b0);
      send_item(NEG_INF, ONE, 1'b1);              // inf on both sides
      send_item(POS_INF, 64'd0, 1'b0);            // inf times zero is nan
      send_item(SNAN, ONE, 1'b0);
      send_item(NEG_INF, MINUS_TWO, 1'b1);
      send_item(MAX_NORM, MAX_NORM, 1'b0);        // overflow
      send_item(MAX_NORM, MINUS_TWO, 1'b1);
      send_item(MIN_SUB, MIN_SUB, 1'b0);          // underflow to zero
      send_item(MAX_SUB, ONE, 1'b0);
      send_item(MIN_SUB, MINUS_TWO, 1'b0);
      send_item(MAX_SUB, MAX_SUB, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
      send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
   endtask

   // random vectors, mostly short, a few long
   task automatic test_random_vectors(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                           : $urandom_range(1, 8);
         send_vector(len);
         sent += len;
      end
   endtask

   // receiver holds off long enough for both queues to fill
   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 12; i++)
         send_vector($urandom_range(1, 3));
   endtask

   // last stretch with no idling on either side
   task automatic test_full_rate();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      test_random_vectors(200);
   endtask

   initial begin
      int waited;
      failed = 1'b0;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      rsp_hold_cycles = 0;
      rx_burst = 0;
      quiet_cycles = 0;
      push = 1'b0;
      pop = 1'b0;
      req_op_a = '0;
      req_op_b = '0;
      req_is_last = 1'b0;
      clear_sums();
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_vectors(700);
      test_backpressure();
      test_random_vectors(800);
      test_full_rate();
      stop_sending();

      waited = 0;
      while (pending_sums.size() != 0 && waited < STALL_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && pending_sums.size() == 0) begin
         $display("[sign_split_dot_product] OK");
      end else begin
         $display("[sign_split_dot_product] ERROR");
      end
      $finish;
   end

endmodule
